// ----- design/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue: transaction
// payloads, entry format, mode and status codes, and cell operations.
// ----------------------------------------------------------------------------
package deq_pkg;

   // Number of entries the queue holds
   localparam int CAPACITY = 16;
   // Width of the internal entry counter (must hold CAPACITY itself)
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   // Width of the reported entry count
   localparam int COUNT_W  = 5;

   // Request mode codes
   localparam logic [1:0] MODE_PUSH_FRONT = 2'd0;
   localparam logic [1:0] MODE_PUSH_BACK  = 2'd1;
   localparam logic [1:0] MODE_POP_FRONT  = 2'd2;
   localparam logic [1:0] MODE_POP_BACK   = 2'd3;

   // Response status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

   // One stored entry
   typedef struct packed {
      logic [7:0] char_val;
      logic [3:0] prec_val;
   } entry_type;

   // Operation broadcast to every cell
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_PUSH_FRONT,
      CELL_PUSH_BACK,
      CELL_POP_FRONT,
      CELL_POP_BACK
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   new_entry;
   } cell_ctrl_type;

   // Request transaction
   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] char_in;
      logic [3:0] prec_in;
   } req_type;

   // Response transaction
   typedef struct packed {
      logic [1:0]         status;
      logic [7:0]         popped_char;
      logic [7:0]         front_char;
      logic [3:0]         front_prec;
      logic [7:0]         back_char;
      logic [3:0]         back_prec;
      logic               is_empty;
      logic               single_entry;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

endpackage

// ----- design/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of character/precedence entries.
// ----------------------------------------------------------------------------
// Each request transaction (push front, push back, pop front, pop back)
// produces exactly one response transaction in the cycle after it is
// accepted, and a new request can be accepted every cycle. The entries
// live in a row of CAPACITY cells with the front in cell 0; a front
// operation shifts the whole row by one slot in that cycle, a back
// operation changes only the tail cell. The response carries the state
// after the operation: a pop on an empty queue reports an underflow and
// a push on a full queue reports an overflow, and neither changes the
// contents. The response sits in an output register, so the request side
// stalls only while a finished response is held by a stalled receiver.
// ----------------------------------------------------------------------------
module double_ended_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  deq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output deq_pkg::rsp_type rsp_data
);
   import deq_pkg::*;

   cell_ctrl_type           ctrl;
   entry_type               cell_entry_ff [CAPACITY];
   entry_type               cell_entry_in [CAPACITY];
   logic [CAPACITY-1:0]     cell_valid_ff;
   logic [CAPACITY-1:0]     cell_valid_in;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_data_ff;
   rsp_type                 rsp_data_in;
   logic                    accept;
   logic                    is_full;
   logic                    is_empty_now;
   logic [1:0]              status;
   entry_type               tail_now;
   entry_type               tail_next;
   entry_type               front_next;

   // Handshake: the output register frees up when taken or empty
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign is_full      = (count_ff == CNT_W'(CAPACITY));
   assign is_empty_now = (count_ff == '0);

   // Decode the request into a cell operation and a status
   always_comb begin
      ctrl.op                 = CELL_HOLD;
      ctrl.new_entry.char_val = req_data.char_in;
      ctrl.new_entry.prec_val = req_data.prec_in;
      status                  = STATUS_OK;
      count_in                = count_ff;
      case (req_data.mode)
         MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            if (is_full) begin
               status = STATUS_OVERFLOW;
            end else if (accept) begin
               ctrl.op  = (req_data.mode == MODE_PUSH_FRONT) ? CELL_PUSH_FRONT
                                                              : CELL_PUSH_BACK;
               count_in = count_ff + CNT_W'(1);
            end
         end
         MODE_POP_FRONT, MODE_POP_BACK: begin
            if (is_empty_now) begin
               status = STATUS_UNDERFLOW;
            end else if (accept) begin
               ctrl.op  = (req_data.mode == MODE_POP_FRONT) ? CELL_POP_FRONT
                                                             : CELL_POP_BACK;
               count_in = count_ff - CNT_W'(1);
            end
         end
         default: begin
            status = STATUS_OK;
         end
      endcase
   end

   // Row of cells, front at index 0
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type left_entry;
      logic      left_valid;
      entry_type right_entry;
      logic      right_valid;

      if (i == 0) begin : g_first
         assign left_entry = ctrl.new_entry;
         assign left_valid = 1'b1;
      end else begin : g_mid
         assign left_entry = cell_entry_ff[i-1];
         assign left_valid = cell_valid_ff[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = '0;
         assign right_valid = 1'b0;
      end else begin : g_inner
         assign right_entry = cell_entry_ff[i+1];
         assign right_valid = cell_valid_ff[i+1];
      end

      deq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_entry  (left_entry),
         .left_valid  (left_valid),
         .right_entry (right_entry),
         .right_valid (right_valid),
         .entry_ff    (cell_entry_ff[i]),
         .valid_ff    (cell_valid_ff[i]),
         .entry_in    (cell_entry_in[i]),
         .valid_in    (cell_valid_in[i])
      );
   end

   // Tail selection: one-hot OR over the cells, before and after the update
   always_comb begin
      tail_now  = '0;
      tail_next = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (cell_valid_ff[i] && (i == CAPACITY - 1 || !cell_valid_ff[(i + 1) % CAPACITY]))
         begin
            tail_now = tail_now | cell_entry_ff[i];
         end
         if (cell_valid_in[i] && (i == CAPACITY - 1 || !cell_valid_in[(i + 1) % CAPACITY]))
         begin
            tail_next = tail_next | cell_entry_in[i];
         end
      end
   end

   assign front_next = cell_valid_in[0] ? cell_entry_in[0] : '0;

   // Response fields reflect the queue after the operation
   always_comb begin
      rsp_data_in              = '0;
      rsp_data_in.status       = status;
      if (status == STATUS_OK) begin
         if (req_data.mode == MODE_POP_FRONT) begin
            rsp_data_in.popped_char = cell_entry_ff[0].char_val;
         end else if (req_data.mode == MODE_POP_BACK) begin
            rsp_data_in.popped_char = tail_now.char_val;
         end
      end
      rsp_data_in.front_char   = front_next.char_val;
      rsp_data_in.front_prec   = front_next.prec_val;
      rsp_data_in.back_char    = tail_next.char_val;
      rsp_data_in.back_prec    = tail_next.prec_val;
      rsp_data_in.is_empty     = (count_in == '0);
      rsp_data_in.single_entry = (count_in <= CNT_W'(1));
      rsp_data_in.entry_count  = COUNT_W'(count_in);
   end

   // Entry counter and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ----- design/deq_cell.sv -----
// ----------------------------------------------------------------------------
// deq_cell
// One slot of the queue. Cell 0 is the front; held entries occupy a
// contiguous run of cells from cell 0. Pushes and pops at the front shift
// the whole row by one position; back operations touch only the tail cell.
// ----------------------------------------------------------------------------
module deq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  deq_pkg::cell_ctrl_type ctrl,
   input  deq_pkg::entry_type     left_entry,
   input  logic                   left_valid,
   input  deq_pkg::entry_type     right_entry,
   input  logic                   right_valid,
   output deq_pkg::entry_type     entry_ff,
   output logic                   valid_ff,
   output deq_pkg::entry_type     entry_in,
   output logic                   valid_in
);
   import deq_pkg::*;

   // Next slot contents
   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      case (ctrl.op)
         CELL_PUSH_FRONT: begin
            entry_in = left_entry;
            valid_in = left_valid;
         end
         CELL_POP_FRONT: begin
            entry_in = right_entry;
            valid_in = right_valid;
         end
         CELL_PUSH_BACK: begin
            // first empty slot after the tail takes the new entry
            if (!valid_ff && left_valid) begin
               entry_in = ctrl.new_entry;
               valid_in = 1'b1;
            end
         end
         CELL_POP_BACK: begin
            // tail slot drops out
            if (valid_ff && !right_valid) begin
               valid_in = 1'b0;
            end
         end
         default: begin
            entry_in = entry_ff;
            valid_in = valid_ff;
         end
      endcase
   end

   // Slot valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Slot payload
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ----- verif/double_ended_queue_tb.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Self-checking testbench for the double-ended queue.
// ----------------------------------------------------------------------------
// A short table of directed operations covers the empty and full corners,
// both push and both pop sides, and the extreme field values. After it comes
// a long random run. That run alternates fill, drain and mixed phases so the
// ring wraps, fills to overflow and drains to underflow many times. A local
// ring-buffer predictor computes each response that the directed table does
// not give. Responses are checked field by field, in order. The sender works
// in random bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import deq_pkg::*;

   localparam int RANDOM_ITEMS = 1600;
   localparam int CYCLE_LIMIT  = 400000;

   typedef enum int {FREE_FLOW, LIGHT_STALL, HEAVY_STALL, PERIODIC_STALL} stall_style_type;
   typedef enum int {FILL_PHASE, DRAIN_PHASE, MIXED_PHASE} phase_kind_type;

   // One line of the directed table; a typed response is used as is
   typedef struct {
      req_type op;
      int      reps;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   double_ended_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Predictor state: ring of entries, head slot and fill level
   logic [7:0] ring_char [CAPACITY];
   logic [3:0] ring_prec [CAPACITY];
   int         head_slot = 0;
   int         fill_level = 0;

   rsp_type       expected_rsp_q [$];
   stim_row_type  directed_rows [$];

   int mismatch_count = 0;
   int sent_count     = 0;
   int rsp_count      = 0;
   int underflow_seen = 0;
   int overflow_seen  = 0;
   int deepest_fill   = 0;
   int burst_left     = 0;
   int cycle_count    = 0;

   // Apply one operation to the predictor and return the response it implies
   function automatic rsp_type apply_deque_op(input req_type op);
      rsp_type res;
      int      slot;
      res = '0;
      res.status = STATUS_OK;
      if (op.mode == MODE_PUSH_FRONT || op.mode == MODE_PUSH_BACK) begin
         if (fill_level == CAPACITY) begin
            res.status = STATUS_OVERFLOW;
         end else begin
            if (op.mode == MODE_PUSH_FRONT) begin
               head_slot = (head_slot + CAPACITY - 1) % CAPACITY;
               slot = head_slot;
            end else begin
               slot = (head_slot + fill_level) % CAPACITY;
            end
            ring_char[slot] = op.char_in;
            ring_prec[slot] = op.prec_in;
            fill_level++;
         end
      end else if (fill_level == 0) begin
         res.status = STATUS_UNDERFLOW;
      end else if (op.mode == MODE_POP_FRONT) begin
         res.popped_char = ring_char[head_slot];
         head_slot = (head_slot + 1) % CAPACITY;
         fill_level--;
      end else begin
         slot = (head_slot + fill_level - 1) % CAPACITY;
         res.popped_char = ring_char[slot];
         fill_level--;
      end
      // Ends of the queue after the operation; an empty queue leaves both ends zero
      if (fill_level != 0) begin
         slot = (head_slot + fill_level - 1) % CAPACITY;
         res.front_char = ring_char[head_slot];
         res.front_prec = ring_prec[head_slot];
         res.back_char  = ring_char[slot];
         res.back_prec  = ring_prec[slot];
      end
      res.is_empty     = (fill_level == 0);
      res.single_entry = (fill_level <= 1);
      res.entry_count  = fill_level[COUNT_W-1:0];
      return res;
   endfunction

   function automatic stim_row_type op_row(input logic [1:0] mode, input logic [7:0] ch,
                                           input logic [3:0] pr, input int reps);
      stim_row_type row;
      row.op.mode    = mode;
      row.op.char_in = ch;
      row.op.prec_in = pr;
      row.reps       = reps;
      row.typed      = 1'b0;
      row.want       = '0;
      return row;
   endfunction

   function automatic stim_row_type exp_row(input logic [1:0] mode, input logic [7:0] ch,
                                            input logic [3:0] pr, input logic [1:0] st,
                                            input logic [7:0] popped, input logic [7:0] fc,
                                            input logic [3:0] fp, input logic [7:0] bc,
                                            input logic [3:0] bp, input logic empty,
                                            input logic single, input int count);
      stim_row_type row;
      row = op_row(mode, ch, pr, 1);
      row.typed             = 1'b1;
      row.want.status       = st;
      row.want.popped_char  = popped;
      row.want.front_char   = fc;
      row.want.front_prec   = fp;
      row.want.back_char    = bc;
      row.want.back_prec    = bp;
      row.want.is_empty     = empty;
      row.want.single_entry = single;
      row.want.entry_count  = count[COUNT_W-1:0];
      return row;
   endfunction

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      $display("%0t: %s mismatch: got 0x%0h, want 0x%0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_response(input rsp_type got, input rsp_type want);
      if (got.status !== want.status)
         flag_mismatch("status", got.status, want.status);
      if (got.popped_char !== want.popped_char)
         flag_mismatch("popped_char", got.popped_char, want.popped_char);
      if (got.front_char !== want.front_char)
         flag_mismatch("front_char", got.front_char, want.front_char);
      if (got.front_prec !== want.front_prec)
         flag_mismatch("front_prec", got.front_prec, want.front_prec);
      if (got.back_char !== want.back_char)
         flag_mismatch("back_char", got.back_char, want.back_char);
      if (got.back_prec !== want.back_prec)
         flag_mismatch("back_prec", got.back_prec, want.back_prec);
      if (got.is_empty !== want.is_empty)
         flag_mismatch("is_empty", got.is_empty, want.is_empty);
      if (got.single_entry !== want.single_entry)
         flag_mismatch("single_entry", got.single_entry, want.single_entry);
      if (got.entry_count !== want.entry_count)
         flag_mismatch("entry_count", got.entry_count, want.entry_count);
   endtask

   // Drive one request and return at the edge where it is accepted
   task automatic send_request(input req_type op, input bit typed, input rsp_type typed_rsp);
      rsp_type predicted;
      req_valid <= 1'b1;
      req_data  <= op;
      do @(posedge clock); while (req_stall);
      predicted = apply_deque_op(op);
      expected_rsp_q.push_back(typed ? typed_rsp : predicted);
      sent_count++;
   endtask

   // Sender bursts: idle for a random gap once the current burst runs out
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(0, 40);
      end
   endtask

   // Receiver stall pattern, switching to a random style when each run ends
   stall_style_type stall_style = FREE_FLOW;
   int              stall_left  = 0;

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_style <= stall_style_type'($urandom_range(0, 3));
         stall_left  <= $urandom_range(16, 96);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_style)
         FREE_FLOW:   rsp_stall <= 1'b0;
         LIGHT_STALL: rsp_stall <= ($urandom_range(0, 3) == 0);
         HEAVY_STALL: rsp_stall <= ($urandom_range(0, 4) != 0);
         default:     rsp_stall <= stall_left[2];
      endcase
   end

   // Response monitor: compare each accepted transaction with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp_q.size() == 0) begin
            flag_mismatch("unexpected response", rsp_data, '0);
         end else begin
            check_response(rsp_data, expected_rsp_q.pop_front());
         end
         rsp_count++;
         if (rsp_data.status == STATUS_UNDERFLOW) underflow_seen++;
         if (rsp_data.status == STATUS_OVERFLOW) overflow_seen++;
         if (int'(rsp_data.entry_count) > deepest_fill)
            deepest_fill = int'(rsp_data.entry_count);
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, expected_rsp_q.size());
      $display("status: fail");
      $finish;
   end

   // Stimulus
   initial begin
      req_type        op;
      phase_kind_type phase;
      int             phase_len;
      int             push_pct;
      int             random_sent;

      // Directed table: empty corners, extremes, fill to overflow
      directed_rows.push_back(exp_row(MODE_POP_FRONT, 8'h00, 4'h0, STATUS_UNDERFLOW,
                                      8'h00, 8'h00, 4'h0, 8'h00, 4'h0, 1'b1, 1'b1, 0));
      directed_rows.push_back(exp_row(MODE_POP_BACK, 8'hFF, 4'hF, STATUS_UNDERFLOW,
                                      8'h00, 8'h00, 4'h0, 8'h00, 4'h0, 1'b1, 1'b1, 0));
      directed_rows.push_back(exp_row(MODE_PUSH_FRONT, 8'hFF, 4'hF, STATUS_OK,
                                      8'h00, 8'hFF, 4'hF, 8'hFF, 4'hF, 1'b0, 1'b1, 1));
      directed_rows.push_back(exp_row(MODE_POP_BACK, 8'h00, 4'h0, STATUS_OK,
                                      8'hFF, 8'h00, 4'h0, 8'h00, 4'h0, 1'b1, 1'b1, 0));
      directed_rows.push_back(exp_row(MODE_PUSH_BACK, 8'h00, 4'h0, STATUS_OK,
                                      8'h00, 8'h00, 4'h0, 8'h00, 4'h0, 1'b0, 1'b1, 1));
      directed_rows.push_back(exp_row(MODE_PUSH_FRONT, 8'h80, 4'h8, STATUS_OK,
                                      8'h00, 8'h80, 4'h8, 8'h00, 4'h0, 1'b0, 1'b0, 2));
      directed_rows.push_back(exp_row(MODE_POP_FRONT, 8'h00, 4'h0, STATUS_OK,
                                      8'h80, 8'h00, 4'h0, 8'h00, 4'h0, 1'b0, 1'b1, 1));
      directed_rows.push_back(exp_row(MODE_POP_FRONT, 8'h00, 4'h0, STATUS_OK,
                                      8'h00, 8'h00, 4'h0, 8'h00, 4'h0, 1'b1, 1'b1, 0));
      directed_rows.push_back(op_row(MODE_PUSH_FRONT, 8'h41, 4'h3, CAPACITY / 2));
      directed_rows.push_back(op_row(MODE_PUSH_BACK, 8'h7A, 4'hC, CAPACITY / 2));
      directed_rows.push_back(exp_row(MODE_PUSH_FRONT, 8'h55, 4'h5, STATUS_OVERFLOW,
                                      8'h00, 8'h41, 4'h3, 8'h7A, 4'hC, 1'b0, 1'b0, CAPACITY));
      directed_rows.push_back(exp_row(MODE_PUSH_BACK, 8'hAA, 4'hA, STATUS_OVERFLOW,
                                      8'h00, 8'h41, 4'h3, 8'h7A, 4'hC, 1'b0, 1'b0, CAPACITY));
      directed_rows.push_back(exp_row(MODE_POP_FRONT, 8'hFF, 4'hF, STATUS_OK, 8'h41,
                                      8'h41, 4'h3, 8'h7A, 4'hC, 1'b0, 1'b0, CAPACITY - 1));
      directed_rows.push_back(op_row(MODE_POP_BACK, 8'h00, 4'h0, 1));
      directed_rows.push_back(op_row(MODE_PUSH_BACK, 8'h5A, 4'h6, 1));
      directed_rows.push_back(op_row(MODE_PUSH_FRONT, 8'hA5, 4'h9, 1));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         repeat (directed_rows[i].reps) begin
            send_request(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].want);
            pace_sender();
         end
      end

      // Random phases: fill and drain phases push the queue to both limits
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         phase     = phase_kind_type'($urandom_range(0, 2));
         phase_len = $urandom_range(8, 48);
         case (phase)
            FILL_PHASE:  push_pct = 85;
            DRAIN_PHASE: push_pct = 15;
            default:     push_pct = 50;
         endcase
         repeat (phase_len) begin
            if ($urandom_range(0, 99) < push_pct)
               op.mode = $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
            else
               op.mode = $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
            op.char_in = $urandom_range(0, 255);
            op.prec_in = $urandom_range(0, 15);
            send_request(op, 1'b0, '0);
            random_sent++;
            pace_sender();
         end
      end
      req_valid <= 1'b0;

      // Drain, then keep watching to catch any stray response
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("ran %0d requests and checked %0d responses in %0d cycles",
               sent_count, rsp_count, cycle_count);
      $display("saw %0d underflows, %0d overflows, deepest fill %0d, %0d mismatches",
               underflow_seen, overflow_seen, deepest_fill, mismatch_count);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
